### src/tun_pkg.sv
`timescale 1ns / 1ps

package tun_pkg;

   // input coordinates and edge vectors
   localparam int CW   = 16;        // coordinate width
   localparam int EW   = CW + 1;    // edge difference width
   localparam int PW   = 2 * EW;    // edge product width
   localparam int CXW  = PW + 1;    // cross component width
   localparam int MW   = CXW - 1;   // cross magnitude width

   // normalization and length
   localparam int LW   = 6;         // bit length code of a magnitude
   localparam int NMW  = 31;        // normalized magnitude width
   localparam int SQW  = 2 * NMW;   // square width
   localparam int SUMW = 64;        // sum of squares width
   localparam int LENW = SUMW / 2;  // length (root) width

   // division and result
   localparam int NF   = 14;                 // result fraction bits
   localparam int QW   = NF + 1;             // quotient width
   localparam int NUMW = NMW + NF + 1;       // dividend width
   localparam int OW   = 16;                 // result field width
   localparam logic [QW-1:0] Q_LIM = QW'(1) << NF;

   // per-item data that rides along with the length computation
   typedef struct packed {
      logic [2:0]          neg;
      logic                degen;
      logic [2:0][NMW-1:0] mag;
   } side_type;

endpackage

### src/triangle_unit_normal.sv
`timescale 1ns / 1ps

// Unit face normal of a triangle. Each item carries three vertices as signed
// Q8.8 coordinates; the block forms the edges from the first vertex, their
// cross product, normalizes it by its length and returns the normal as three
// signed Q1.14 components, rounded to nearest and clamped to plus or minus
// one. A triangle whose cross product is zero gives a zero normal with
// degenerate set. The datapath is a fully pipelined chain: 8 stages of edge,
// product, cross, normalize and square-sum logic, a 32-stage square root that
// resolves one bit of the length per stage, then 17 stages of division: one
// for dividend setup, 15 that each resolve one quotient bit in three parallel
// lanes, and one for clamping; then the output register. An item enters every
// cycle unless the pipeline is frozen; results leave the rsp_ side in order.
// A two-entry output buffer decouples req_ready from rsp_ready: the pipeline
// freezes only once both output entries are full.

module triangle_unit_normal import tun_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [CW-1:0] req_v1_x,
   input  logic signed [CW-1:0] req_v1_y,
   input  logic signed [CW-1:0] req_v1_z,
   input  logic signed [CW-1:0] req_v2_x,
   input  logic signed [CW-1:0] req_v2_y,
   input  logic signed [CW-1:0] req_v2_z,
   input  logic signed [CW-1:0] req_v3_x,
   input  logic signed [CW-1:0] req_v3_y,
   input  logic signed [CW-1:0] req_v3_z,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [OW-1:0] rsp_normal_x,
   output logic signed [OW-1:0] rsp_normal_y,
   output logic signed [OW-1:0] rsp_normal_z,
   output logic                 rsp_degenerate
);

   // pipeline advance: every stage moves while the skid entry is free
   logic                 en;

   logic                 fr_valid;
   logic [SUMW-1:0]      fr_sum;
   side_type             fr_side;

   logic                 sq_valid;
   logic [LENW-1:0]      sq_len;
   side_type             sq_side;

   logic                 dv_valid;
   logic signed [OW-1:0] dv_nx, dv_ny, dv_nz;
   logic                 dv_dg;

   // output register and skid entry
   logic                 out_valid_ff, out_valid_in;
   logic signed [OW-1:0] out_nx_ff, out_ny_ff, out_nz_ff;
   logic signed [OW-1:0] out_nx_in, out_ny_in, out_nz_in;
   logic                 out_dg_ff, out_dg_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic signed [OW-1:0] skid_nx_ff, skid_ny_ff, skid_nz_ff;
   logic signed [OW-1:0] skid_nx_in, skid_ny_in, skid_nz_in;
   logic                 skid_dg_ff, skid_dg_in;

   logic                 take;
   logic                 arrive;

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   tun_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_v1_x  (req_v1_x),
      .in_v1_y  (req_v1_y),
      .in_v1_z  (req_v1_z),
      .in_v2_x  (req_v2_x),
      .in_v2_y  (req_v2_y),
      .in_v2_z  (req_v2_z),
      .in_v3_x  (req_v3_x),
      .in_v3_y  (req_v3_y),
      .in_v3_z  (req_v3_z),
      .out_valid(fr_valid),
      .out_sum  (fr_sum),
      .out_side (fr_side)
   );

   tun_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (fr_valid),
      .in_sum   (fr_sum),
      .in_side  (fr_side),
      .out_valid(sq_valid),
      .out_len  (sq_len),
      .out_side (sq_side)
   );

   tun_div u_div (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (sq_valid),
      .in_len        (sq_len),
      .in_side       (sq_side),
      .out_valid     (dv_valid),
      .out_normal_x  (dv_nx),
      .out_normal_y  (dv_ny),
      .out_normal_z  (dv_nz),
      .out_degenerate(dv_dg)
   );

   // an item leaves the pipeline only on an advancing cycle
   assign take   = out_valid_ff && rsp_ready;
   assign arrive = dv_valid && en;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_nx_in     = out_nx_ff;
      out_ny_in     = out_ny_ff;
      out_nz_in     = out_nz_ff;
      out_dg_in     = out_dg_ff;
      skid_valid_in = skid_valid_ff;
      skid_nx_in    = skid_nx_ff;
      skid_ny_in    = skid_ny_ff;
      skid_nz_in    = skid_nz_ff;
      skid_dg_in    = skid_dg_ff;
      if (skid_valid_ff) begin
         // pipeline is frozen, drain the skid entry into the output
         if (take) begin
            out_nx_in     = skid_nx_ff;
            out_ny_in     = skid_ny_ff;
            out_nz_in     = skid_nz_ff;
            out_dg_in     = skid_dg_ff;
            skid_valid_in = 1'b0;
         end
      end else if (arrive) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_nx_in    = dv_nx;
            out_ny_in    = dv_ny;
            out_nz_in    = dv_nz;
            out_dg_in    = dv_dg;
         end else begin
            // output still held, park the new item
            skid_valid_in = 1'b1;
            skid_nx_in    = dv_nx;
            skid_ny_in    = dv_ny;
            skid_nz_in    = dv_nz;
            skid_dg_in    = dv_dg;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_nx_ff  <= out_nx_in;
      out_ny_ff  <= out_ny_in;
      out_nz_ff  <= out_nz_in;
      out_dg_ff  <= out_dg_in;
      skid_nx_ff <= skid_nx_in;
      skid_ny_ff <= skid_ny_in;
      skid_nz_ff <= skid_nz_in;
      skid_dg_ff <= skid_dg_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_normal_x   = out_nx_ff;
   assign rsp_normal_y   = out_ny_ff;
   assign rsp_normal_z   = out_nz_ff;
   assign rsp_degenerate = out_dg_ff;

endmodule

### src/tun_front.sv
`timescale 1ns / 1ps

module tun_front import tun_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] in_v1_x,
   input  logic signed [CW-1:0] in_v1_y,
   input  logic signed [CW-1:0] in_v1_z,
   input  logic signed [CW-1:0] in_v2_x,
   input  logic signed [CW-1:0] in_v2_y,
   input  logic signed [CW-1:0] in_v2_z,
   input  logic signed [CW-1:0] in_v3_x,
   input  logic signed [CW-1:0] in_v3_y,
   input  logic signed [CW-1:0] in_v3_z,
   output logic                 out_valid,
   output logic [SUMW-1:0]      out_sum,
   output side_type             out_side
);

   logic signed [CW-1:0]  p [9];
   logic [7:0]            v_ff;

   logic signed [EW-1:0]  e1_in [3], e2_in [3], e1_ff [3], e2_ff [3];
   logic signed [PW-1:0]  prod_in [6], prod_ff [6];
   logic signed [CXW-1:0] cross_in [3], cross_ff [3];
   logic [MW-1:0]         mag_in [3], mag_ff [3], mag2_ff [3];
   logic [2:0]            neg_in, neg_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [LW-1:0]         bl_in, bl_ff;
   logic [NMW-1:0]        nm_in [3], nm_ff [3], nm2_ff [3];
   logic                  degen_in, degen_ff, degen2_ff;
   logic [SQW-1:0]        sq_in [3], sq_ff [3];
   logic [SUMW-1:0]       sum_in, sum_ff;
   side_type              side_in, side_ff;

   assign p[0] = in_v1_x;
   assign p[1] = in_v1_y;
   assign p[2] = in_v1_z;
   assign p[3] = in_v2_x;
   assign p[4] = in_v2_y;
   assign p[5] = in_v2_z;
   assign p[6] = in_v3_x;
   assign p[7] = in_v3_y;
   assign p[8] = in_v3_z;

   // edges
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = {p[3+i][CW-1], p[3+i]} - {p[i][CW-1], p[i]};
         e2_in[i] = {p[6+i][CW-1], p[6+i]} - {p[i][CW-1], p[i]};
      end
   end

   // edge products
   always_comb begin
      prod_in[0] = e1_ff[1] * e2_ff[2];
      prod_in[1] = e1_ff[2] * e2_ff[1];
      prod_in[2] = e1_ff[2] * e2_ff[0];
      prod_in[3] = e1_ff[0] * e2_ff[2];
      prod_in[4] = e1_ff[0] * e2_ff[1];
      prod_in[5] = e1_ff[1] * e2_ff[0];
   end

   // cross product
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cross_in[i] = CXW'(prod_ff[2*i]) - CXW'(prod_ff[2*i+1]);
      end
   end

   // magnitudes and signs
   always_comb begin
      logic signed [CXW-1:0] ab;
      ab = '0;
      for (int i = 0; i < 3; i++) begin
         ab        = cross_ff[i][CXW-1] ? -cross_ff[i] : cross_ff[i];
         mag_in[i] = ab[MW-1:0];
         neg_in[i] = cross_ff[i][CXW-1];
      end
   end

   // bit length of the largest magnitude
   always_comb begin
      logic [MW-1:0] orv;
      orv   = mag_ff[0] | mag_ff[1] | mag_ff[2];
      bl_in = '0;
      for (int i = 0; i < MW; i++) begin
         if (orv[i]) begin
            bl_in = LW'(i + 1);
         end
      end
   end

   // bring the largest magnitude into [2^30, 2^31)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (bl_ff > LW'(NMW)) begin
            nm_in[i] = NMW'(mag2_ff[i] >> (bl_ff - LW'(NMW)));
         end else begin
            nm_in[i] = NMW'(mag2_ff[i] << (LW'(NMW) - bl_ff));
         end
      end
      degen_in = (bl_ff == '0);
   end

   // squares
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQW'(nm_ff[i]) * SQW'(nm_ff[i]);
      end
   end

   // sum of squares
   always_comb begin
      sum_in        = SUMW'(sq_ff[0]) + SUMW'(sq_ff[1]) + SUMW'(sq_ff[2]);
      side_in.neg   = neg4_ff;
      side_in.degen = degen2_ff;
      for (int i = 0; i < 3; i++) begin
         side_in.mag[i] = nm2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[6:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff     <= e1_in;
         e2_ff     <= e2_in;
         prod_ff   <= prod_in;
         cross_ff  <= cross_in;
         mag_ff    <= mag_in;
         neg_ff    <= neg_in;
         bl_ff     <= bl_in;
         mag2_ff   <= mag_ff;
         neg2_ff   <= neg_ff;
         nm_ff     <= nm_in;
         degen_ff  <= degen_in;
         neg3_ff   <= neg2_ff;
         sq_ff     <= sq_in;
         nm2_ff    <= nm_ff;
         degen2_ff <= degen_ff;
         neg4_ff   <= neg3_ff;
         sum_ff    <= sum_in;
         side_ff   <= side_in;
      end
   end

   assign out_valid = v_ff[7];
   assign out_sum   = sum_ff;
   assign out_side  = side_ff;

endmodule

### src/tun_sqrt.sv
`timescale 1ns / 1ps

module tun_sqrt import tun_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [SUMW-1:0] in_sum,
   input  side_type        in_side,
   output logic            out_valid,
   output logic [LENW-1:0] out_len,
   output side_type        out_side
);

   localparam int STEPS = LENW;
   localparam int RW    = LENW + 2;

   logic [STEPS-1:0] v_ff;
   logic [SUMW-1:0]  x_in [STEPS], x_ff [STEPS];
   logic [RW-1:0]    rem_in [STEPS], rem_ff [STEPS];
   logic [LENW-1:0]  root_in [STEPS], root_ff [STEPS];
   side_type         side_in [STEPS], side_ff [STEPS];

   // one result bit per stage, restoring square root
   always_comb begin
      logic [SUMW-1:0] xs;
      logic [RW-1:0]   rs;
      logic [LENW-1:0] qs;
      logic [RW+1:0]   sh;
      logic [RW+1:0]   trial;
      xs    = '0;
      rs    = '0;
      qs    = '0;
      sh    = '0;
      trial = '0;
      for (int s = 0; s < STEPS; s++) begin
         if (s == 0) begin
            xs         = in_sum;
            rs         = '0;
            qs         = '0;
            side_in[s] = in_side;
         end else begin
            xs         = x_ff[s-1];
            rs         = rem_ff[s-1];
            qs         = root_ff[s-1];
            side_in[s] = side_ff[s-1];
         end
         sh      = {rs, xs[SUMW-1:SUMW-2]};
         trial   = (RW+2)'({qs, 2'b01});
         x_in[s] = xs << 2;
         if (sh >= trial) begin
            rem_in[s]  = RW'(sh - trial);
            root_in[s] = {qs[LENW-2:0], 1'b1};
         end else begin
            rem_in[s]  = RW'(sh);
            root_in[s] = {qs[LENW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_len   = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

### src/tun_div.sv
`timescale 1ns / 1ps

module tun_div import tun_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [LENW-1:0]      in_len,
   input  side_type             in_side,
   output logic                 out_valid,
   output logic signed [OW-1:0] out_normal_x,
   output logic signed [OW-1:0] out_normal_y,
   output logic signed [OW-1:0] out_normal_z,
   output logic                 out_degenerate
);

   localparam int STEPS = QW;

   // dividend setup
   logic            pv_ff;
   logic [NUMW-1:0] num_in [3], num_ff [3];
   logic [LENW-1:0] plen_ff;
   side_type        pside_ff;

   // quotient steps
   logic [STEPS-1:0] v_ff;
   logic [LENW-1:0]  rem_in [STEPS][3], rem_ff [STEPS][3];
   logic [QW-1:0]    lo_in [STEPS][3], lo_ff [STEPS][3];
   logic [LENW-1:0]  len_in [STEPS], len_ff [STEPS];
   side_type         side_in [STEPS], side_ff [STEPS];

   // saturated and signed result
   logic                 ov_ff;
   logic signed [OW-1:0] nrm_in [3], nrm_ff [3];
   logic                 dg_ff;

   // rounding: add half the length before dividing
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num_in[k] = NUMW'({in_side.mag[k], {NF{1'b0}}}) + NUMW'(in_len[LENW-1:1]);
      end
   end

   // one quotient bit per stage and lane, restoring division
   always_comb begin
      logic [LENW-1:0] rs;
      logic [QW-1:0]   ls;
      logic [LENW-1:0] ds;
      logic [LENW:0]   sh;
      logic [LENW:0]   df;
      rs = '0;
      ls = '0;
      ds = '0;
      sh = '0;
      df = '0;
      for (int s = 0; s < STEPS; s++) begin
         if (s == 0) begin
            ds         = plen_ff;
            side_in[s] = pside_ff;
         end else begin
            ds         = len_ff[s-1];
            side_in[s] = side_ff[s-1];
         end
         len_in[s] = ds;
         for (int k = 0; k < 3; k++) begin
            if (s == 0) begin
               rs = LENW'(num_ff[k][NUMW-1:QW]);
               ls = num_ff[k][QW-1:0];
            end else begin
               rs = rem_ff[s-1][k];
               ls = lo_ff[s-1][k];
            end
            sh = {rs, ls[QW-1]};
            df = sh - {1'b0, ds};
            if (sh >= {1'b0, ds}) begin
               rem_in[s][k] = df[LENW-1:0];
               lo_in[s][k]  = {ls[QW-2:0], 1'b1};
            end else begin
               rem_in[s][k] = sh[LENW-1:0];
               lo_in[s][k]  = {ls[QW-2:0], 1'b0};
            end
         end
      end
   end

   // clamp to one, apply sign, zero on a degenerate triangle
   always_comb begin
      logic [QW-1:0] qc;
      qc = '0;
      for (int k = 0; k < 3; k++) begin
         qc = (lo_ff[STEPS-1][k] > Q_LIM) ? Q_LIM : lo_ff[STEPS-1][k];
         if (side_ff[STEPS-1].degen) begin
            nrm_in[k] = '0;
         end else if (side_ff[STEPS-1].neg[k]) begin
            nrm_in[k] = -OW'(qc);
         end else begin
            nrm_in[k] = OW'(qc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         v_ff  <= '0;
         ov_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= in_valid;
         v_ff  <= {v_ff[STEPS-2:0], pv_ff};
         ov_ff <= v_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff   <= num_in;
         plen_ff  <= in_len;
         pside_ff <= in_side;
         rem_ff   <= rem_in;
         lo_ff    <= lo_in;
         len_ff   <= len_in;
         side_ff  <= side_in;
         nrm_ff   <= nrm_in;
         dg_ff    <= side_ff[STEPS-1].degen;
      end
   end

   assign out_valid      = ov_ff;
   assign out_normal_x   = nrm_ff[0];
   assign out_normal_y   = nrm_ff[1];
   assign out_normal_z   = nrm_ff[2];
   assign out_degenerate = dg_ff;

endmodule

### src/tun_checker.sv
`timescale 1ns / 1ps

module tun_checker import tun_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic signed [OW-1:0] rsp_normal_x,
   input logic signed [OW-1:0] rsp_normal_y,
   input logic signed [OW-1:0] rsp_normal_z,
   input logic                 rsp_degenerate
);

   localparam logic signed [OW-1:0] ONE  = OW'(Q_LIM);
   localparam logic signed [OW-1:0] MONE = -OW'(Q_LIM);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normal_x)
         && $stable(rsp_normal_y) && $stable(rsp_normal_z) && $stable(rsp_degenerate))
      else $error("result changed while stalled");

   // degenerate items carry a zero normal
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate item with nonzero normal");

   // a real normal is never the zero vector
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         !(rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0))
      else $error("zero normal without degenerate flag");

   // components stay within plus or minus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x <= ONE && rsp_normal_x >= MONE
         && rsp_normal_y <= ONE && rsp_normal_y >= MONE
         && rsp_normal_z <= ONE && rsp_normal_z >= MONE)
      else $error("normal component out of range");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (.*);
